### src/cdcs_pkg.sv
package cdcs_pkg;

  localparam int IN_W  = 32;
  localparam int OUT_W = 72;
  localparam int VAL_W = 16;
  localparam int ACC_W = 40;
  localparam int Z_W   = 26;
  localparam int P_W   = 43;
  localparam int F_W   = 28;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_WEIGHT = 2'd1,
    OP_BIAS   = 2'd2,
    OP_HIST   = 2'd3
  } op_t;

  localparam logic [1:0] MODE_ZERO  = 2'd1;
  localparam logic [1:0] MODE_CARRY = 2'd2;

  localparam logic CFG_SILU = 1'b0;
  localparam logic CFG_BIAS = 1'b1;

  typedef struct packed {
    op_t                      op;
    logic [5:0]               channel;
    logic [1:0]               tap;
    logic signed [VAL_W-1:0]  value;
    logic [1:0]               mode;
    logic                     real_sample;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  // piecewise-linear sigmoid, unsigned Q1.15
  function automatic logic [15:0] sigmoid_q15(logic signed [Z_W-1:0] z);
    logic [Z_W-1:0] a;
    logic [Z_W-1:0] s;
    a = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
    if (a >= Z_W'(1280)) begin
      s = Z_W'(32768);
    end else if (a >= Z_W'(608)) begin
      s = Z_W'(27648) + (a << 2);
    end else if (a >= Z_W'(256)) begin
      s = Z_W'(20480) + (a << 4);
    end else begin
      s = Z_W'(16384) + (a << 5);
    end
    if (z[Z_W-1]) begin
      s = Z_W'(32768) - s;
    end
    return s[15:0];
  endfunction

endpackage

### src/cdcs_front.sv
module cdcs_front import cdcs_pkg::*; #(
  parameter int CHANNELS = 64,
  parameter int TAPS     = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  back_ctl_t       ctl,
  output q_head_t         head
);

  cmd_t       dec;
  logic       keep;
  logic       push;
  cmd_t       ent_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  always_comb begin
    dec.op          = op_t'(in_tdata[1:0]);
    dec.channel     = in_tdata[7:2];
    dec.tap         = in_tdata[9:8];
    dec.value       = in_tdata[25:10];
    dec.mode        = in_tdata[27:26];
    dec.real_sample = in_tdata[28];
    keep = int'(dec.channel) < CHANNELS;
    case (dec.op)
      OP_WEIGHT: keep = keep && (int'(dec.tap) < TAPS);
      OP_HIST:   keep = keep && (int'(dec.tap) < TAPS - 1);
      default:   keep = keep;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2) && !ctl.clearing;
  assign push      = in_tvalid && in_tready && keep;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !ctl.pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && ctl.pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (ctl.pop) begin
        rptr_r <= !rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= dec;
    end
  end

  assign head.valid = cnt_r != 2'd0;
  assign head.cmd   = ent_r[rptr_r];

endmodule

### src/cdcs_back.sv
module cdcs_back import cdcs_pkg::*; #(
  parameter int CHANNELS = 64,
  parameter int TAPS     = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_head_t          head,
  output back_ctl_t        ctl,
  input  logic             silu_enable,
  input  logic             bias_enable,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WW = TAPS * VAL_W;
  localparam int HW = (TAPS - 1) * VAL_W;
  localparam int KW = $clog2(TAPS + 1);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_READ  = 8'b00000100,
    ST_MAC   = 8'b00001000,
    ST_ROUND = 8'b00010000,
    ST_SIG   = 8'b00100000,
    ST_MUL   = 8'b01000000,
    ST_FINAL = 8'b10000000
  } state_t;

  state_t state_r;

  logic [WW-1:0]    w_mem  [CHANNELS];
  logic [VAL_W-1:0] b_mem  [CHANNELS];
  logic [HW-1:0]    wh_mem [CHANNELS];
  logic [HW-1:0]    ch_mem [CHANNELS];

  logic [WW-1:0]    w_rd_r;
  logic [VAL_W-1:0] b_rd_r;
  logic [HW-1:0]    wh_rd_r;
  logic [HW-1:0]    ch_rd_r;

  cmd_t             cmd_r;
  logic [CW-1:0]    rd_addr;
  logic [CW-1:0]    wr_addr;
  logic [CW+5:0]    rd_ext;
  logic [CW+5:0]    wr_ext;
  logic [CW-1:0]    clr_cnt_r;

  logic [WW-1:0]    w_upd;
  logic [HW-1:0]    ch_upd;
  logic [HW-1:0]    hsel;
  logic [HW-1:0]    csel;
  logic [HW-1:0]    wh_new;
  logic [HW-1:0]    ch_new;

  logic [HW-1:0]            hist_r;
  logic [KW-1:0]            k_r;
  logic signed [VAL_W-1:0]  op_a;
  logic signed [VAL_W-1:0]  op_b;
  logic signed [31:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [Z_W-1:0]    z_r;
  logic [15:0]              s_r;
  logic signed [16:0]       s_ext;
  logic signed [P_W-1:0]    p_r;
  logic signed [P_W-1:0]    p_rnd;
  logic signed [F_W-1:0]    fin;
  logic signed [VAL_W-1:0]  res;
  logic                     sat;
  logic [47:0]              carried_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_load;

  function automatic logic [HW-1:0] shift_in(logic [HW-1:0] h, logic [VAL_W-1:0] x);
    logic [HW-1:0] n;
    n = h;
    for (int i = 0; i < TAPS - 2; i++) begin
      n[i*VAL_W +: VAL_W] = h[(i+1)*VAL_W +: VAL_W];
    end
    n[(TAPS-2)*VAL_W +: VAL_W] = x;
    return n;
  endfunction

  always_comb begin
    rd_ext  = {{CW{1'b0}}, head.cmd.channel};
    wr_ext  = {{CW{1'b0}}, cmd_r.channel};
    rd_addr = rd_ext[CW-1:0];
    wr_addr = wr_ext[CW-1:0];
  end

  // register update for the write commands and the sample history paths
  always_comb begin
    w_upd  = w_rd_r;
    ch_upd = ch_rd_r;
    for (int i = 0; i < TAPS; i++) begin
      if (int'(cmd_r.tap) == i) begin
        w_upd[i*VAL_W +: VAL_W] = cmd_r.value;
      end
    end
    for (int i = 0; i < TAPS - 1; i++) begin
      if (int'(cmd_r.tap) == i) begin
        ch_upd[i*VAL_W +: VAL_W] = cmd_r.value;
      end
    end
    if (cmd_r.mode == MODE_ZERO) begin
      hsel = '0;
      csel = '0;
    end else if (cmd_r.mode == MODE_CARRY) begin
      hsel = ch_rd_r;
      csel = ch_rd_r;
    end else begin
      hsel = wh_rd_r;
      csel = ch_rd_r;
    end
    wh_new = shift_in(hsel, cmd_r.value);
    ch_new = cmd_r.real_sample ? shift_in(csel, cmd_r.value) : csel;
  end

  // MAC operands: history slots first, current sample with the newest weight last
  always_comb begin
    op_a = cmd_r.value;
    op_b = '0;
    for (int i = 0; i < TAPS - 1; i++) begin
      if (int'(k_r) == i) begin
        op_a = hist_r[i*VAL_W +: VAL_W];
      end
    end
    for (int i = 0; i < TAPS; i++) begin
      if (int'(k_r) == i) begin
        op_b = w_rd_r[i*VAL_W +: VAL_W];
      end
    end
  end

  always_comb begin
    acc_rnd = acc_r + ACC_W'(8192);
    p_rnd   = p_r + P_W'(16384);
    s_ext   = {1'b0, s_r};
    if (silu_enable) begin
      fin = p_rnd[P_W-1:15];
    end else begin
      fin = {{(F_W-Z_W){z_r[Z_W-1]}}, z_r};
    end
    sat = 1'b0;
    res = fin[VAL_W-1:0];
    if (fin > F_W'(32767)) begin
      res = 16'sh7fff;
      sat = 1'b1;
    end else if (fin < -F_W'(32768)) begin
      res = 16'sh8000;
      sat = 1'b1;
    end
  end

  assign out_load = (state_r == ST_FINAL) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + CW'(1);
          if (clr_cnt_r == CW'(CHANNELS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (head.valid) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          k_r     <= '0;
          state_r <= (cmd_r.op == OP_SAMPLE) ? ST_MAC : ST_IDLE;
        end
        ST_MAC: begin
          k_r <= k_r + KW'(1);
          if (k_r == KW'(TAPS)) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: state_r <= silu_enable ? ST_SIG : ST_FINAL;
        ST_SIG:   state_r <= ST_MUL;
        ST_MUL:   state_r <= ST_FINAL;
        ST_FINAL: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && head.valid) begin
      cmd_r   <= head.cmd;
      w_rd_r  <= w_mem[rd_addr];
      b_rd_r  <= b_mem[rd_addr];
      wh_rd_r <= wh_mem[rd_addr];
      ch_rd_r <= ch_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      wh_mem[clr_cnt_r] <= '0;
      ch_mem[clr_cnt_r] <= '0;
    end else if (state_r == ST_READ) begin
      case (cmd_r.op)
        OP_WEIGHT: w_mem[wr_addr] <= w_upd;
        OP_BIAS:   b_mem[wr_addr] <= cmd_r.value;
        OP_HIST:   ch_mem[wr_addr] <= ch_upd;
        default: begin
          wh_mem[wr_addr] <= wh_new;
          ch_mem[wr_addr] <= ch_new;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_READ: begin
        hist_r    <= hsel;
        carried_r <= 48'(ch_new);
        acc_r     <= bias_enable ? {{(ACC_W-VAL_W-14){b_rd_r[VAL_W-1]}}, b_rd_r, 14'd0} : '0;
      end
      ST_MAC: begin
        prod_r <= op_a * op_b;
        if (k_r != '0) begin
          acc_r <= acc_r + {{(ACC_W-32){prod_r[31]}}, prod_r};
        end
      end
      ST_ROUND: z_r <= acc_rnd[ACC_W-1:14];
      ST_SIG:   s_r <= sigmoid_q15(z_r);
      ST_MUL:   p_r <= z_r * s_ext;
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_r <= {{(OUT_W-65){1'b0}}, carried_r, sat, res};
    end
  end

  assign ctl.pop      = (state_r == ST_IDLE) && head.valid;
  assign ctl.clearing = state_r == ST_CLEAR;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

### src/causal_depthwise_conv1d_silu_top.sv
// Flow: a sample transaction passes the queue, then ST_IDLE, ST_READ, ST_MAC, ST_ROUND,
//   ST_SIG, ST_MUL (SiLU on only), ST_FINAL; weight, bias and history writes land in ST_READ.
// Datapath: the back end works on one command at a time, the front queue holds two more;
//   one multiplier walks the taps one per cycle, a second forms the SiLU product.
// Reset: rst_n is synchronous, active low; afterwards the history memories are cleared
//   one channel per cycle with in_tready low. Config resets to 0.
module causal_depthwise_conv1d_silu_top import cdcs_pkg::*; #(
  parameter int CHANNELS = 64,
  parameter int TAPS     = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata, LSB up: operation[1:0], channel[7:2], tap_index[9:8], value[25:10],
  //   start_mode[27:26], real_sample[28], zero fill [31:29]
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  // out_tdata, LSB up: result[15:0], saturated[16], carried_oldest[32:17],
  //   carried_middle[48:33], carried_newest[64:49], zero fill [71:65]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  // config: index 0 silu_enable, index 1 bias_enable
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic             cfg_data
);

  logic      silu_en_r;
  logic      bias_en_r;
  q_head_t   head;
  back_ctl_t ctl;

  // The user must write config only while idle (the block does not enforce it), so the back end samples it directly.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silu_en_r <= 1'b0;
      bias_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SILU: silu_en_r <= cfg_data;
        CFG_BIAS: bias_en_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: decode, drop out-of-range transactions, 2-deep command queue.
  cdcs_front #(
    .CHANNELS (CHANNELS),
    .TAPS     (TAPS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ctl       (ctl),
    .head      (head)
  );

  // Back: per-channel memories, history update, serial MAC, SiLU, output register.
  cdcs_back #(
    .CHANNELS (CHANNELS),
    .TAPS     (TAPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .ctl         (ctl),
    .silu_enable (silu_en_r),
    .bias_enable (bias_en_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // a saturated result sits at one of the rails
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[16]) |->
      (out_tdata[15:0] == 16'h7fff || out_tdata[15:0] == 16'h8000))
    else $error("saturated result not at a rail");

  // no input transaction is taken during the history clearing pass
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clearing |-> !in_tready)
    else $error("input accepted while clearing");

  // no result appears before the clearing pass is done
  a_clr_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clearing |-> !out_tvalid)
    else $error("result while clearing");

endmodule

### tb/causal_depthwise_conv1d_silu_top_test.sv
`timescale 1ns / 100ps

module causal_depthwise_conv1d_silu_top_test;
  import cdcs_pkg::*;

  localparam int NCH = 64;
  localparam int NTAP = 4;
  localparam int DRAIN_CYCLES = 40;   // covers the sample latency with margin
  localparam int CYCLE_LIMIT = 600000;

  // expected result transaction, laid out as out_tdata[64:0] (MSB first)
  typedef struct packed {
    logic signed [15:0] c_new;
    logic signed [15:0] c_mid;
    logic signed [15:0] c_old;
    logic               sat;
    logic signed [15:0] result;
  } conv_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;

  causal_depthwise_conv1d_silu_top #(.CHANNELS(NCH), .TAPS(NTAP)) uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [15:0] weight_mem [NCH][NTAP];
  logic signed [15:0] bias_mem [NCH];
  logic signed [15:0] work_hist [NCH][NTAP-1];
  logic signed [15:0] carry_hist [NCH][NTAP-1];
  logic silu_on = 1'b0;
  logic bias_on = 1'b0;

  conv_out_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_sat = 0;
  int cycles = 0;
  bit idle_on = 1'b1;   // random gaps on both sides; cleared for the last stretch

  // round-to-nearest (ties up) arithmetic shift
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sigmoid_fix(longint z);
    longint a, s;
    a = (z < 0) ? -z : z;
    if (a >= 1280) s = 32768;
    else if (a >= 608) s = 27648 + 4 * a;
    else if (a >= 256) s = 20480 + 16 * a;
    else s = 16384 + 32 * a;
    return (z < 0) ? 32768 - s : s;
  endfunction

  // applies one accepted transaction to the predictor; queues a result for samples
  task automatic predict_conv(op_t op, int ch, int tap, logic signed [15:0] val,
                              logic [1:0] mode, logic real_s);
    longint acc, z;
    conv_out_t e;
    if (op == OP_WEIGHT) begin
      weight_mem[ch][tap] = val;
    end else if (op == OP_BIAS) begin
      bias_mem[ch] = val;
    end else if (op == OP_HIST) begin
      if (tap < NTAP - 1) carry_hist[ch][tap] = val;
    end else begin
      if (mode == MODE_ZERO) begin
        for (int i = 0; i < NTAP - 1; i++) begin
          work_hist[ch][i] = '0;
          carry_hist[ch][i] = '0;
        end
      end else if (mode == MODE_CARRY) begin
        work_hist[ch] = carry_hist[ch];
      end
      acc = longint'(weight_mem[ch][NTAP-1]) * longint'(val);
      for (int i = 0; i < NTAP - 1; i++)
        acc += longint'(weight_mem[ch][i]) * longint'(work_hist[ch][i]);
      if (bias_on) acc += longint'(bias_mem[ch]) * 16384;
      z = round_shift(acc, 14);
      if (silu_on) z = round_shift(z * sigmoid_fix(z), 15);
      e.sat = 1'b0;
      if (z > 32767) begin
        z = 32767;
        e.sat = 1'b1;
      end else if (z < -32768) begin
        z = -32768;
        e.sat = 1'b1;
      end
      e.result = z[15:0];
      for (int i = 0; i < NTAP - 2; i++) work_hist[ch][i] = work_hist[ch][i+1];
      work_hist[ch][NTAP-2] = val;
      if (real_s) begin
        for (int i = 0; i < NTAP - 2; i++) carry_hist[ch][i] = carry_hist[ch][i+1];
        carry_hist[ch][NTAP-2] = val;
      end
      e.c_old = carry_hist[ch][0];
      e.c_mid = carry_hist[ch][1];
      e.c_new = carry_hist[ch][2];
      expected_q.push_back(e);
    end
  endtask

  // sends one transaction with an optional random gap before it
  task automatic send_item(op_t op, int ch, int tap, logic signed [15:0] val,
                           logic [1:0] mode, logic real_s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tdata <= {3'b000, real_s, mode, val, tap[1:0], ch[5:0], op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_conv(op, ch, tap, val, mode, real_s);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only while idle
  task automatic write_reg(logic idx, logic val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SILU) silu_on = val;
    else bias_on = val;
  endtask

  task automatic set_mode(logic silu, logic bias);
    wait_drained();
    write_reg(CFG_SILU, silu);
    write_reg(CFG_BIAS, bias);
    cfg_valid <= 1'b0;
  endtask

  // weights and bias for every channel so no sample reads an unwritten entry
  task automatic load_coefficients(bit extremes);
    logic signed [15:0] w;
    for (int ch = 0; ch < NCH; ch++) begin
      for (int t = 0; t < NTAP; t++) begin
        w = extremes ? ((t % 2) ? 16'sh7fff : 16'sh8000) : 16'($urandom_range(0, 65535));
        send_item(OP_WEIGHT, ch, t, w, 2'd0, 1'b0);
      end
      send_item(OP_BIAS, ch, 0, 16'($urandom), 2'd0, 1'b0);
    end
  endtask

  task automatic rand_sample(int ch);
    send_item(OP_SAMPLE, ch, $urandom_range(0, 3), 16'($urandom),
              2'($urandom_range(0, 3)), 1'($urandom));
  endtask

  // field extremes, every operation, start modes 0..3, ignored tap index
  task automatic test_directed();
    set_mode(1'b0, 1'b0);
    load_coefficients(1'b1);
    send_item(OP_SAMPLE, 0, 0, 16'sh7fff, MODE_ZERO, 1'b1);
    send_item(OP_SAMPLE, 0, 3, 16'sh8000, 2'd0, 1'b1);
    send_item(OP_SAMPLE, 0, 0, 16'sh7fff, 2'd3, 1'b0);  // mode 3 acts as continue
    send_item(OP_HIST, 63, 0, 16'sh8000, 2'd0, 1'b0);
    send_item(OP_HIST, 63, 2, 16'sh7fff, 2'd0, 1'b0);
    send_item(OP_HIST, 63, 3, 16'sh1234, 2'd0, 1'b0);  // out-of-range slot, ignored
    send_item(OP_SAMPLE, 63, 0, 16'sh0100, MODE_CARRY, 1'b1);
    send_item(OP_SAMPLE, 63, 0, 16'sh0000, MODE_ZERO, 1'b0);
    send_item(OP_WEIGHT, 1, 3, 16'sh4000, 2'd0, 1'b0);
    send_item(OP_SAMPLE, 1, 0, 16'shffff, MODE_ZERO, 1'b1);
    set_mode(1'b1, 1'b1);
    send_item(OP_SAMPLE, 0, 0, 16'sh8000, MODE_ZERO, 1'b1);
    send_item(OP_SAMPLE, 1, 0, 16'sh0300, MODE_ZERO, 1'b1);
    send_item(OP_SAMPLE, 1, 0, 16'shfd00, 2'd0, 1'b1);
    send_item(OP_SAMPLE, 1, 0, 16'sh0080, 2'd0, 1'b0);
  endtask

  // sequences per channel with random content, under each config setting
  task automatic test_random(int n_items);
    int ch;
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0], ph[1]);
      if (ph == 0) load_coefficients(1'b0);
      if (ph == 3) idle_on = 1'b0;
      for (int i = 0; i < n_items / 4; i++) begin
        ch = $urandom_range(0, 7) == 0 ? $urandom_range(0, NCH - 1) : $urandom_range(0, 3);
        case ($urandom_range(0, 9))
          0: send_item(OP_HIST, ch, $urandom_range(0, 3), 16'($urandom),
                       2'($urandom), 1'($urandom));
          1: send_item(OP_WEIGHT, ch, $urandom_range(0, 3), 16'($urandom),
                       2'($urandom), 1'($urandom));
          2: send_item(OP_BIAS, ch, $urandom_range(0, 3), 16'($urandom),
                       2'($urandom), 1'($urandom));
          default: rand_sample(ch);
        endcase
      end
    end
  endtask

  // result checker with random backpressure
  always @(posedge clk) begin
    conv_out_t got, e;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[64:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors <= errors + 1;
      end else begin
        e = expected_q.pop_front();
        n_results <= n_results + 1;
        if (got.sat) n_sat <= n_sat + 1;
        if (got !== e || out_tdata[71:65] !== 7'd0) begin
          $display("%0t: mismatch expected res=%0d sat=%0b c=%0d/%0d/%0d",
                   $time, e.result, e.sat, e.c_old, e.c_mid, e.c_new);
          $display("%0t:          actual res=%0d sat=%0b c=%0d/%0d/%0d",
                   $time, got.result, got.sat, got.c_old, got.c_mid, got.c_new);
          errors <= errors + 1;
        end
      end
    end
    if (!idle_on) out_tready <= 1'b1;
    else if ($urandom_range(0, 4) == 0) out_tready <= ~out_tready;
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < NCH; c++) begin
      for (int i = 0; i < NTAP - 1; i++) begin
        work_hist[c][i] = '0;
        carry_hist[c][i] = '0;
      end
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(400);
    wait_drained();
    $display("covered %0d results (%0d saturated) over all silu/bias settings",
             n_results, n_sat);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
src/cdcs_pkg.sv
src/cdcs_front.sv
src/cdcs_back.sv
src/causal_depthwise_conv1d_silu_top.sv
tb/causal_depthwise_conv1d_silu_top_test.sv
